// ===== hdl/mbe_pkg.sv =====
// Package for the Mandelbrot escape-time block: payload structs, sequencer
// states, register indexes, reset values and the saturation helper.
// No dependencies.
`timescale 1ns / 1ps
package mbe_pkg;

  localparam int DEF_FRAC_BITS = 28;
  localparam int DEF_ITER_BITS = 16;

  localparam int DATA_W     = 32;
  localparam int PROD_W     = 64;
  localparam int COUNT_W    = 16;
  localparam int BAIL_W     = 31;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_BAILOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXITER = 1'b1;

  localparam logic [BAIL_W-1:0]  BAILOUT_RST = 31'h4000_0000;
  localparam logic [COUNT_W-1:0] MAXITER_RST = 16'd255;

  localparam logic signed [PROD_W-1:0] MAG_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [PROD_W-1:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [PROD_W-1:0] S32_MIN = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] z_re;
    logic signed [DATA_W-1:0] z_im;
    logic signed [DATA_W-1:0] c_re;
    logic signed [DATA_W-1:0] c_im;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] iteration_count;
    logic               escaped;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_XX,
    S_YY,
    S_XY,
    S_UPD,
    S_FIN
  } mbe_state_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > S32_MAX) begin
      r = S32_MAX[DATA_W-1:0];
    end else if (v < S32_MIN) begin
      r = S32_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/mbe_cfg.sv =====
// Configuration registers of the Mandelbrot escape-time block: bailout
// threshold and iteration limit. Depends on mbe_pkg.
`timescale 1ns / 1ps
module mbe_cfg
  import mbe_pkg::*;
#(
  parameter int ITER_BITS = DEF_ITER_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic [BAIL_W-1:0]     bailout,
  output logic [ITER_BITS-1:0]  limit
);

  logic [BAIL_W-1:0]    bail_r, bail_nxt;
  logic [ITER_BITS-1:0] lim_r, lim_nxt;

  always_comb begin
    bail_nxt = bail_r;
    lim_nxt  = lim_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_BAILOUT: bail_nxt = cfg_wdata[BAIL_W-1:0];
        CFG_MAXITER: lim_nxt  = ITER_BITS'(cfg_wdata[COUNT_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bail_r <= BAILOUT_RST;
      lim_r  <= ITER_BITS'(MAXITER_RST);
    end else begin
      bail_r <= bail_nxt;
      lim_r  <= lim_nxt;
    end
  end

  assign bailout = bail_r;
  assign limit   = lim_r;

endmodule

// ===== hdl/mbe_mul.sv =====
// Shared signed 32x32 multiplier with a registered product and a
// floor-rounding shift back to the fixed-point scale. Depends on mbe_pkg.
`timescale 1ns / 1ps
module mbe_mul
  import mbe_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                     clk,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  input  logic                     half,
  output logic signed [PROD_W-1:0] q
);

  logic signed [PROD_W-1:0] p_r;
  logic                     half_r;

  always_ff @(posedge clk) begin
    p_r    <= PROD_W'(a) * PROD_W'(b);
    half_r <= half;
  end

  assign q = half_r ? (p_r >>> (FRAC_BITS - 1)) : (p_r >>> FRAC_BITS);

endmodule

// ===== hdl/mbe_core.sv =====
// Iteration sequencer and datapath of the Mandelbrot escape-time block.
// Uses one mbe_mul for all squares and cross products. Depends on mbe_pkg.
`timescale 1ns / 1ps
module mbe_core
  import mbe_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int ITER_BITS = DEF_ITER_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  in_item_t             in_data,
  output logic                 busy,
  input  logic [BAIL_W-1:0]    bailout,
  input  logic [ITER_BITS-1:0] limit,
  output logic                 res_valid,
  output out_item_t            res_data,
  input  logic                 res_take
);

  mbe_state_t state_r, state_nxt;

  logic signed [DATA_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [DATA_W-1:0] cre_r, cre_nxt, cim_r, cim_nxt;
  logic signed [PROD_W-1:0] xx_r, xx_nxt, yy_r, yy_nxt;
  logic [ITER_BITS-1:0]     cnt_r, cnt_nxt;
  logic                     first_r, first_nxt;
  out_item_t                res_r, res_nxt;

  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic                     mul_half;
  logic signed [PROD_W-1:0] q;
  logic signed [PROD_W-1:0] mag, re_sum, im_sum;
  logic                     over, esc, accept;

  mbe_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .half (mul_half),
    .q    (q)
  );

  assign accept = (state_r == S_IDLE) && in_valid;
  assign mag    = xx_r + q;
  assign over   = mag > MAG_MAX;
  assign esc    = !first_r && (over || (mag[BAIL_W-1:0] >= bailout));
  assign re_sum = xx_r - yy_r + PROD_W'(cre_r);
  assign im_sum = q + PROD_W'(cim_r);

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    cre_nxt   = cre_r;
    cim_nxt   = cim_r;
    xx_nxt    = xx_r;
    yy_nxt    = yy_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    res_nxt   = res_r;
    mul_a     = x_r;
    mul_b     = x_r;
    mul_half  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x_nxt     = in_data.z_re;
          y_nxt     = in_data.z_im;
          cre_nxt   = in_data.c_re;
          cim_nxt   = in_data.c_im;
          cnt_nxt   = '0;
          first_nxt = 1'b1;
          state_nxt = S_XX;
        end
      end
      S_XX: begin
        state_nxt = S_YY;
      end
      S_YY: begin
        xx_nxt    = q;
        mul_a     = y_r;
        mul_b     = y_r;
        state_nxt = S_XY;
      end
      S_XY: begin
        yy_nxt = q;
        if (esc) begin
          res_nxt.iteration_count = COUNT_W'(cnt_r);
          res_nxt.escaped         = 1'b1;
          state_nxt               = S_FIN;
        end else begin
          mul_b     = y_r;
          mul_half  = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        x_nxt = sat32(re_sum);
        y_nxt = sat32(im_sum);
        if (cnt_r == limit) begin
          res_nxt.iteration_count = '0;
          res_nxt.escaped         = 1'b0;
          state_nxt               = S_FIN;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          first_nxt = 1'b0;
          state_nxt = S_XX;
        end
      end
      S_FIN: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    cre_r   <= cre_nxt;
    cim_r   <= cim_nxt;
    xx_r    <= xx_nxt;
    yy_r    <= yy_nxt;
    cnt_r   <= cnt_nxt;
    first_r <= first_nxt;
    res_r   <= res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign res_valid = (state_r == S_FIN);
  assign res_data  = res_r;

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_XX))
    else $error("sequencer did not start after an input transfer");

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) && (state_r != S_XX) |-> (cnt_r <= limit))
    else $error("step counter ran past the iteration limit");

  a_upd_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |=> (state_r == S_XX) || (state_r == S_FIN))
    else $error("update step not followed by a new square or a result");

  a_bounded_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_data.escaped |-> (res_data.iteration_count == '0))
    else $error("bounded result carries a nonzero count");

endmodule

// ===== hdl/mandelbrot_escape_time.sv =====
// Top level of the Mandelbrot escape-time block: configuration registers,
// iteration core and output register. Depends on mbe_pkg, mbe_cfg, mbe_core.
//
// One input transfer carries z0 and c in signed Q4.28; one result transfer
// carries the escape count and the escaped flag. A transfer happens on a
// rising edge where valid is high and stall is low. Each iteration steps
// through x*x, y*y, x*y and update on the single shared multiplier.
// The next point is taken once the core has handed its result to the
// output register. While the receiver stalls, the result waits in the
// output register and the core holds the following result until the
// register frees up. Reset sets the bailout threshold to 4.0 and the
// limit to 255 and drops any point in progress. Configuration writes
// belong to idle time.
`timescale 1ns / 1ps
module mandelbrot_escape_time
  import mbe_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int ITER_BITS = DEF_ITER_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [BAIL_W-1:0]    bailout;
  logic [ITER_BITS-1:0] limit;
  logic                 busy, res_valid, res_take;
  out_item_t            res_data;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  mbe_cfg #(.ITER_BITS(ITER_BITS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .bailout   (bailout),
    .limit     (limit)
  );

  mbe_core #(.FRAC_BITS(FRAC_BITS), .ITER_BITS(ITER_BITS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .busy      (busy),
    .bailout   (bailout),
    .limit     (limit),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_take  (res_take)
  );

  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
